>>> src/mfrd_pkg.sv
// Shared types and constants for the monochrome framebuffer rectangle engine.
// No dependencies; mfrd_ctrl, mfrd_datapath and the top level use it.
package mfrd_pkg;

    localparam int PIX_PER_BYTE = 8;
    localparam int BIT_SEL_W    = 3;   // row bits inside one byte

    typedef enum logic [1:0] {
        MODE_FILL_RECT = 2'd0,
        MODE_OUTLINE   = 2'd1,
        MODE_FILL_ALL  = 2'd2,
        MODE_READ      = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [8:0]  start_x;
        logic [7:0]  start_y;
        logic [8:0]  rect_width;
        logic [7:0]  rect_height;
        logic        ink;
        logic [7:0]  fill_byte;
        logic [12:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic rect_rd;
        logic rect_wr;
        logic sweep_wr;
        logic index_rd;
        logic out_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        mode_t in_mode;
        logic  empty;
        logic  walk_last;
        logic  sweep_last;
    } dp_status_t;

endpackage

>>> src/mfrd_stream_if.sv
// Valid/ready channel carrying one payload item per transfer.
// Payload type is supplied by the instantiating level (see mfrd_pkg).
interface mfrd_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> src/mfrd_ctrl.sv
// Command sequencer for the framebuffer engine: clear sweep, rectangle walk,
// store fill, byte read and result hand-off. Depends on mfrd_pkg.
module mfrd_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  mfrd_pkg::dp_status_t sts,
    output mfrd_pkg::dp_cmd_t    ctl
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_WR    = 8'b0001_0000,
        S_FILL  = 8'b0010_0000,
        S_RDB   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    unique case (sts.in_mode) inside
                        mfrd_pkg::MODE_FILL_RECT, mfrd_pkg::MODE_OUTLINE:
                            state_next = S_SETUP;
                        mfrd_pkg::MODE_FILL_ALL:
                            state_next = S_FILL;
                        default:
                            state_next = S_RDB;
                    endcase
                end
            end
            S_SETUP:
            begin
                state_next = sts.empty ? S_DONE : S_RD;
            end
            S_RD:
            begin
                ctl.rect_rd = 1'b1;
                state_next  = S_WR;
            end
            S_WR:
            begin
                ctl.rect_wr = 1'b1;
                state_next  = sts.walk_last ? S_DONE : S_RD;
            end
            S_FILL:
            begin
                ctl.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_RDB:
            begin
                ctl.index_rd = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("engine still ready after a command transfer");

    a_single_port: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.rect_rd, ctl.rect_wr, ctl.sweep_wr, ctl.index_rd}))
        else $error("two store accesses in one cycle");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> (!ctl.out_load && out_valid_reg))
        else $error("result load not followed by a held result");

endmodule

>>> src/mfrd_datapath.sv
// Framebuffer store, rectangle walk counters, mask/merge logic and result register.
// Depends on mfrd_pkg; driven by mfrd_ctrl.
module mfrd_datapath #(
    parameter int unsigned SCREEN_WIDTH  = 296,
    parameter int unsigned SCREEN_HEIGHT = 128
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mfrd_pkg::in_item_t   in_item,
    input  mfrd_pkg::dp_cmd_t    ctl,
    output mfrd_pkg::dp_status_t sts,
    output mfrd_pkg::out_item_t  out_item
);

    localparam int unsigned COL_BYTES =
        (SCREEN_HEIGHT + mfrd_pkg::PIX_PER_BYTE - 1) / mfrd_pkg::PIX_PER_BYTE;
    localparam int unsigned STORE_BYTES = SCREEN_WIDTH * COL_BYTES;
    localparam int AW = $clog2(STORE_BYTES);
    localparam int BW = (COL_BYTES > 1) ? $clog2(COL_BYTES) : 1;

    logic [7:0] mem [STORE_BYTES];

    mfrd_pkg::mode_t     mode_reg;
    logic [8:0]          x0_reg;
    logic [7:0]          y0_reg;
    logic [8:0]          x1_reg;
    logic [7:0]          y1_reg;
    logic [9:0]          xl_reg;
    logic [8:0]          yl_reg;
    logic                ink_reg;
    logic [7:0]          fill_reg;
    logic [AW-1:0]       idx_reg;
    logic                idx_ok_reg;
    logic [8:0]          col_reg;
    logic [AW-1:0]       col_base_reg;
    logic [BW-1:0]       byte_reg;
    logic [AW-1:0]       sweep_reg;
    logic [7:0]          rd_data_reg;
    mfrd_pkg::out_item_t out_reg;

    logic [9:0]    x_sum;
    logic [8:0]    y_sum;
    logic [8:0]    x1_next;
    logic [7:0]    y1_next;
    logic [AW-1:0] base_next;
    logic [7:0]    y1_m1;
    logic [BW-1:0] last_byte;
    logic [BW-1:0] first_byte;
    logic [AW-1:0] rect_addr;
    logic          outline;
    logic          col_edge;
    logic [7:0]    mask;
    logic [7:0]    merged;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic          mem_re;
    logic [7:0]    mem_wdata;

    // clip against the screen at load time; far edges kept unclipped for outline
    assign x_sum     = 10'(in_item.start_x) + 10'(in_item.rect_width);
    assign y_sum     = 9'(in_item.start_y) + 9'(in_item.rect_height);
    assign x1_next   = (x_sum > 10'(SCREEN_WIDTH)) ? 9'(SCREEN_WIDTH) : x_sum[8:0];
    assign y1_next   = (y_sum > 9'(SCREEN_HEIGHT)) ? 8'(SCREEN_HEIGHT) : y_sum[7:0];
    assign base_next = AW'(in_item.start_x * COL_BYTES);

    assign y1_m1      = y1_reg - 8'd1;
    assign last_byte  = y1_m1[mfrd_pkg::BIT_SEL_W +: BW];
    assign first_byte = y0_reg[mfrd_pkg::BIT_SEL_W +: BW];
    assign rect_addr  = col_base_reg + AW'(byte_reg);

    assign outline  = (mode_reg == mfrd_pkg::MODE_OUTLINE);
    assign col_edge = (col_reg == x0_reg) || (10'(col_reg) == xl_reg);

    always_comb
    begin
        logic [8:0] y_row;
        logic       in_rows;
        logic       on_edge;
        for (int r = 0; r < mfrd_pkg::PIX_PER_BYTE; r++)
        begin
            y_row   = 9'({byte_reg, 3'(r)});
            in_rows = (y_row >= 9'(y0_reg)) && (y_row < 9'(y1_reg));
            on_edge = !outline || col_edge || (y_row == 9'(y0_reg)) || (y_row == yl_reg);
            mask[mfrd_pkg::PIX_PER_BYTE - 1 - r] = in_rows && on_edge;
        end
    end

    assign merged = ink_reg ? (rd_data_reg | mask) : (rd_data_reg & ~mask);

    always_comb
    begin
        if (ctl.sweep_wr)
        begin
            mem_addr = sweep_reg;
        end
        else if (ctl.index_rd)
        begin
            mem_addr = idx_reg;
        end
        else
        begin
            mem_addr = rect_addr;
        end
    end

    assign mem_we    = ctl.rect_wr || ctl.sweep_wr;
    assign mem_re    = ctl.rect_rd || (ctl.index_rd && idx_ok_reg);
    assign mem_wdata = ctl.sweep_wr ? fill_reg : merged;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // sweep runs from reset with a zero fill byte: that is the power-on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            sweep_reg <= '0;
        end
        else if (ctl.load)
        begin
            fill_reg  <= in_item.fill_byte;
            sweep_reg <= '0;
        end
        else if (ctl.sweep_wr)
        begin
            sweep_reg <= sweep_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mode_reg     <= in_item.mode;
            x0_reg       <= in_item.start_x;
            y0_reg       <= in_item.start_y;
            x1_reg       <= x1_next;
            y1_reg       <= y1_next;
            xl_reg       <= x_sum - 10'd1;
            yl_reg       <= y_sum - 9'd1;
            ink_reg      <= in_item.ink;
            idx_reg      <= AW'(in_item.read_index);
            idx_ok_reg   <= (32'(in_item.read_index) < STORE_BYTES);
            col_reg      <= in_item.start_x;
            col_base_reg <= base_next;
            byte_reg     <= in_item.start_y[mfrd_pkg::BIT_SEL_W +: BW];
        end
        else if (ctl.rect_wr)
        begin
            if (byte_reg == last_byte)
            begin
                byte_reg     <= first_byte;
                col_reg      <= col_reg + 9'd1;
                col_base_reg <= col_base_reg + AW'(COL_BYTES);
            end
            else
            begin
                byte_reg <= byte_reg + BW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_reg.read_valid <= (mode_reg == mfrd_pkg::MODE_READ);
            out_reg.read_data  <= (mode_reg == mfrd_pkg::MODE_READ && idx_ok_reg)
                                  ? rd_data_reg : 8'h00;
        end
    end

    assign sts.in_mode    = in_item.mode;
    assign sts.empty      = (x0_reg >= x1_reg) || (y0_reg >= y1_reg);
    assign sts.walk_last  = (byte_reg == last_byte) && (col_reg == x1_reg - 9'd1);
    assign sts.sweep_last = (sweep_reg == AW'(STORE_BYTES - 1));
    assign out_item       = out_reg;

    a_rect_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rect_wr |-> (32'(rect_addr) < STORE_BYTES))
        else $error("rectangle walk left the store");

    a_rmw_same_byte: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rect_wr |-> ($past(ctl.rect_rd) && $stable(rect_addr)))
        else $error("write-back not paired with the read of the same byte");

endmodule

>>> src/mono_framebuffer_rect_draw.sv
// Monochrome column-organized framebuffer drawing engine (top level).
// Depends on mfrd_pkg, mfrd_stream_if, mfrd_ctrl and mfrd_datapath.
//
// One command in, one result out. The store is a single-port byte memory of
// SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) entries (4736 at 296x128), and every
// command time is set by passes over that one port. After reset the engine
// clears the store, writing every byte once, before taking a command. Fill-store
// writes its fill byte to every store byte. A rectangle or outline reads, then
// merges and writes back, each byte touched in its clipped area, after a setup
// state and before the hand-off; an empty or fully clipped rectangle goes from
// setup straight to hand-off. A byte read reads at most one store byte.
// A finished result sits in an output register; the engine goes on to the
// next command while it waits, and stalls only when a second result is due.
module mono_framebuffer_rect_draw #(
    parameter int unsigned SCREEN_WIDTH  = 296,
    parameter int unsigned SCREEN_HEIGHT = 128
)
(
    input  logic           clk,
    input  logic           rst_n,
    mfrd_stream_if.sink    cmd,
    mfrd_stream_if.source  rsp
);

    mfrd_pkg::dp_cmd_t    ctl;
    mfrd_pkg::dp_status_t sts;
    mfrd_pkg::out_item_t  out_item;
    logic                 in_ready;
    logic                 out_valid;

    mfrd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    mfrd_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (cmd.data),
        .ctl      (ctl),
        .sts      (sts),
        .out_item (out_item)
    );

    assign cmd.ready = in_ready;
    assign rsp.valid = out_valid;
    assign rsp.data  = out_item;

endmodule

>>> bench/rect_draw_checker.sv
`timescale 1ns / 1ps
// Watches the command and result channels of the rectangle draw engine, keeps its own
// copy of the frame store and checks every result in order. Depends on mfrd_pkg.
module rect_draw_checker
#(
    parameter int SCREEN_WIDTH  = 296,
    parameter int SCREEN_HEIGHT = 128
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_ready,
    input  mfrd_pkg::in_item_t  cmd_data,
    input  logic                rsp_valid,
    input  logic                rsp_ready,
    input  mfrd_pkg::out_item_t rsp_data,
    output int unsigned         failures,
    output int unsigned         waiting
);

    localparam int COL_BYTES   =
        (SCREEN_HEIGHT + mfrd_pkg::PIX_PER_BYTE - 1) / mfrd_pkg::PIX_PER_BYTE;
    localparam int STORE_BYTES = SCREEN_WIDTH * COL_BYTES;
    localparam logic [7:0] TOP_PIXEL = 8'h80;
    localparam int REPORT_MAX = 10;

    logic [7:0]          frame_model [STORE_BYTES];
    mfrd_pkg::out_item_t due_results [$];
    int unsigned         fail_count = 0;
    int unsigned         due_count  = 0;

    assign failures = fail_count;
    assign waiting  = due_count;

    function automatic void plot(input int x, input int y, input logic ink);
        int         idx;
        logic [7:0] mask;
        idx  = x * COL_BYTES + y / mfrd_pkg::PIX_PER_BYTE;
        mask = TOP_PIXEL >> (y % mfrd_pkg::PIX_PER_BYTE);
        if (ink)
            frame_model[idx] = frame_model[idx] | mask;
        else
            frame_model[idx] = frame_model[idx] & ~mask;
    endfunction

    // Clipped box; the hollow form keeps only the first/last row and column.
    function automatic void draw_box(input mfrd_pkg::in_item_t c, input bit hollow);
        int x0, y0, w, h, x_end, y_end;
        x0 = c.start_x;
        y0 = c.start_y;
        w  = c.rect_width;
        h  = c.rect_height;
        if (w == 0 || h == 0)
            return;
        x_end = (x0 + w > SCREEN_WIDTH)  ? SCREEN_WIDTH  : x0 + w;
        y_end = (y0 + h > SCREEN_HEIGHT) ? SCREEN_HEIGHT : y0 + h;
        for (int px = x0; px < x_end; px++)
        begin
            for (int py = y0; py < y_end; py++)
            begin
                if (hollow && px != x0 && px != x0 + w - 1 && py != y0 && py != y0 + h - 1)
                    continue;
                plot(px, py, c.ink);
            end
        end
    endfunction

    function automatic mfrd_pkg::out_item_t run_command(input mfrd_pkg::in_item_t c);
        mfrd_pkg::out_item_t r;
        r = '0;
        case (c.mode)
            mfrd_pkg::MODE_FILL_RECT: draw_box(c, 1'b0);
            mfrd_pkg::MODE_OUTLINE:   draw_box(c, 1'b1);
            mfrd_pkg::MODE_FILL_ALL:  foreach (frame_model[i]) frame_model[i] = c.fill_byte;
            mfrd_pkg::MODE_READ:
            begin
                r.read_valid = 1'b1;
                if (int'(c.read_index) < STORE_BYTES)
                    r.read_data = frame_model[c.read_index];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void note_failure(input string what,
                                         input mfrd_pkg::out_item_t want,
                                         input mfrd_pkg::out_item_t got);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: %s: expected data %02h valid %0b, got data %02h valid %0b",
                     $realtime, what, want.read_data, want.read_valid,
                     got.read_data, got.read_valid);
    endfunction

    always @(posedge clk)
    begin
        mfrd_pkg::out_item_t want;
        if (!rst_n)
        begin
            foreach (frame_model[i]) frame_model[i] = '0;
            due_results.delete();
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_results.size() == 0)
                    note_failure("result with nothing due", '0, rsp_data);
                else
                begin
                    want = due_results.pop_front();
                    if (rsp_data.read_data !== want.read_data ||
                        rsp_data.read_valid !== want.read_valid)
                        note_failure("result mismatch", want, rsp_data);
                end
            end
            if (cmd_valid && cmd_ready)
                due_results.push_back(run_command(cmd_data));
        end
        due_count = due_results.size();
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Top of the rectangle draw engine bench: clock, reset, command stimulus and verdict.
// Depends on mfrd_pkg, mfrd_stream_if, mono_framebuffer_rect_draw and rect_draw_checker.
module tb;

    localparam int SW           = 296;
    localparam int SH           = 128;
    localparam int COL_BYTES    =
        (SH + mfrd_pkg::PIX_PER_BYTE - 1) / mfrd_pkg::PIX_PER_BYTE;
    localparam int STORE_BYTES  = SW * COL_BYTES;
    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_TAIL   = 60;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int ITEM_W       = $bits(mfrd_pkg::in_item_t);

    logic clk;
    logic rst_n;

    mfrd_stream_if #(.payload_t(mfrd_pkg::in_item_t))  cmd ();
    mfrd_stream_if #(.payload_t(mfrd_pkg::out_item_t)) rsp ();

    int unsigned failures;
    int unsigned waiting;

    // gap knob is only read by the sender; the stall knob goes through an NBA
    // so the result side picks it up at a clean edge
    int  gap_pct   = 0;
    int  stall_pct = 0;

    // last drawn box, so that reads land where something happened
    int  last_x = 0;
    int  last_y = 0;
    int  last_w = 1;
    int  last_h = 1;

    mono_framebuffer_rect_draw #(
        .SCREEN_WIDTH  (SW),
        .SCREEN_HEIGHT (SH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    rect_draw_checker #(
        .SCREEN_WIDTH  (SW),
        .SCREEN_HEIGHT (SH)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd_data  (cmd.data),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp.data),
        .failures  (failures),
        .waiting   (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: random stall bursts, cut short once stalls are off
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0 && stall_pct != 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (rst_n && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(0, 3);
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= rst_n;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int byte_at(input int x, input int y);
        return x * COL_BYTES + y / mfrd_pkg::PIX_PER_BYTE;
    endfunction

    function automatic mfrd_pkg::in_item_t rect_cmd(input mfrd_pkg::mode_t m,
                                                    input int x, input int y,
                                                    input int w, input int h,
                                                    input bit ink);
        mfrd_pkg::in_item_t c;
        c.mode        = m;
        c.start_x     = x[8:0];
        c.start_y     = y[7:0];
        c.rect_width  = w[8:0];
        c.rect_height = h[7:0];
        c.ink         = ink;
        c.fill_byte   = 8'($urandom);
        c.read_index  = 13'($urandom);
        if (w != 0 && h != 0 && x < SW && y < SH)
        begin
            last_x = x;
            last_y = y;
            last_w = w;
            last_h = h;
        end
        return c;
    endfunction

    function automatic mfrd_pkg::in_item_t fill_cmd(input logic [7:0] value);
        mfrd_pkg::in_item_t c;
        c           = mfrd_pkg::in_item_t'(ITEM_W'({$urandom, $urandom}));
        c.mode      = mfrd_pkg::MODE_FILL_ALL;
        c.fill_byte = value;
        return c;
    endfunction

    function automatic mfrd_pkg::in_item_t read_cmd(input int index);
        mfrd_pkg::in_item_t c;
        c            = mfrd_pkg::in_item_t'(ITEM_W'({$urandom, $urandom}));
        c.mode       = mfrd_pkg::MODE_READ;
        c.read_index = index[12:0];
        return c;
    endfunction

    // read near the edges or inside of the last box drawn
    function automatic mfrd_pkg::in_item_t read_near_cmd();
        int col, row;
        col = last_x + $urandom_range(0, last_w) - 1;
        row = last_y + $urandom_range(0, last_h) - 1;
        if (col < 0 || col >= SW)
            col = $urandom_range(0, SW - 1);
        if (row < 0 || row >= SH)
            row = $urandom_range(0, SH - 1);
        return read_cmd(byte_at(col, row));
    endfunction

    function automatic mfrd_pkg::in_item_t random_cmd();
        int              roll, geom, x, y, w, h;
        mfrd_pkg::mode_t m;
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            case ($urandom_range(0, 3))
                0:       return fill_cmd(8'h00);
                1:       return fill_cmd(8'hFF);
                default: return fill_cmd(8'($urandom));
            endcase
        end
        if (roll < 58)
        begin
            m    = (roll < 38) ? mfrd_pkg::MODE_FILL_RECT : mfrd_pkg::MODE_OUTLINE;
            geom = $urandom_range(0, 99);
            if (geom < 82)
            begin
                x = $urandom_range(0, SW + 4);
                y = $urandom_range(0, SH + 4);
                w = $urandom_range(0, 20);
                h = $urandom_range(0, 24);
            end
            else if (geom < 90)
            begin
                x = SW - $urandom_range(0, 8);
                y = SH - $urandom_range(0, 10);
                w = $urandom_range(0, 30);
                h = $urandom_range(0, 30);
            end
            else
            begin
                x = $urandom_range(0, 511);
                y = $urandom_range(0, 255);
                w = $urandom_range(0, 511);
                h = $urandom_range(0, 255);
            end
            return rect_cmd(m, x, y, w, h, $urandom_range(0, 1));
        end
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return read_near_cmd();
        if (roll < 90)
            return read_cmd($urandom_range(0, STORE_BYTES - 1));
        return read_cmd($urandom_range(0, 8191));
    endfunction

    // valid stays high from one command to the next unless a gap is inserted or the bench waits for results
    task automatic push_cmd(input mfrd_pkg::in_item_t c);
        cmd.valid <= 1'b1;
        cmd.data  <= c;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    task automatic wait_results_done();
        cmd.valid <= 1'b0;
        do
            @(negedge clk);
        while (waiting != 0);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cmd.valid <= 1'b0;
        cmd.data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: corners, clipping, empty boxes, outlines, out-of-range reads
        push_cmd(read_cmd(0));
        push_cmd(read_cmd(STORE_BYTES - 1));
        push_cmd(rect_cmd(mfrd_pkg::MODE_FILL_RECT, 0, 0, 1, 1, 1'b1));
        push_cmd(read_cmd(0));
        push_cmd(rect_cmd(mfrd_pkg::MODE_FILL_RECT, 0, 0, 511, 255, 1'b1));
        push_cmd(read_cmd(STORE_BYTES - 1));
        push_cmd(rect_cmd(mfrd_pkg::MODE_FILL_RECT, 3, 3, 0, 5, 1'b0));
        push_cmd(rect_cmd(mfrd_pkg::MODE_FILL_RECT, 3, 3, 5, 0, 1'b0));
        push_cmd(read_cmd(byte_at(3, 3)));
        push_cmd(rect_cmd(mfrd_pkg::MODE_OUTLINE, 10, 3, 20, 20, 1'b0));
        push_cmd(read_cmd(byte_at(10, 8)));
        push_cmd(read_cmd(byte_at(15, 22)));
        push_cmd(rect_cmd(mfrd_pkg::MODE_OUTLINE, 290, 125, 2, 2, 1'b0));
        push_cmd(rect_cmd(mfrd_pkg::MODE_OUTLINE, 40, 9, 1, 7, 1'b0));
        push_cmd(rect_cmd(mfrd_pkg::MODE_OUTLINE, 511, 255, 511, 255, 1'b0));
        push_cmd(rect_cmd(mfrd_pkg::MODE_FILL_RECT, SW - 1, SH - 1, 511, 255, 1'b0));
        push_cmd(read_cmd(STORE_BYTES - 1));
        push_cmd(read_cmd(STORE_BYTES));
        push_cmd(read_cmd(8191));
        push_cmd(fill_cmd(8'hA5));
        push_cmd(rect_cmd(mfrd_pkg::MODE_OUTLINE, 100, 60, 50, 40, 1'b1));
        push_cmd(read_cmd(byte_at(149, 70)));
        push_cmd(fill_cmd(8'h00));
        push_cmd(rect_cmd(mfrd_pkg::MODE_FILL_RECT, 7, 5, 3, 9, 1'b1));
        push_cmd(read_cmd(byte_at(8, 8)));

        wait_results_done();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n >= RANDOM_ITEMS - QUIET_TAIL)
            begin
                gap_pct    = 0;
                stall_pct <= 0;
            end
            else if (n % 60 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       begin gap_pct = 0;  stall_pct <= 0;  end
                    1:       begin gap_pct = 20; stall_pct <= 25; end
                    default: begin gap_pct = 50; stall_pct <= 50; end
                endcase
            end
            if (n == RANDOM_ITEMS / 2)
                wait_results_done();
            if ($urandom_range(0, 99) < gap_pct)
            begin
                cmd.valid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            push_cmd(random_cmd());
        end

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && waiting == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
